// ===== design/round_robin_task_scheduler_assert.svh =====
// Assertion macros for the round-robin task scheduler.
// Each check is skipped in synthesis.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrts assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrts assertion failed");

`else

`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/rrts_pkg.sv =====
`default_nettype none

package rrts_pkg;

  // command codes
  localparam logic [3:0] OP_SCHEDULE = 4'd0;
  localparam logic [3:0] OP_CREATE   = 4'd1;
  localparam logic [3:0] OP_DELETE   = 4'd2;
  localparam logic [3:0] OP_BLOCK    = 4'd3;
  localparam logic [3:0] OP_UNBLOCK  = 4'd4;
  localparam logic [3:0] OP_SLEEP    = 4'd5;
  localparam logic [3:0] OP_TICK     = 4'd6;
  localparam logic [3:0] OP_EXIT     = 4'd7;
  localparam logic [3:0] OP_COMPACT  = 4'd8;

  // result status codes
  localparam logic [2:0] RS_OK        = 3'd0;
  localparam logic [2:0] RS_FULL      = 3'd1;
  localparam logic [2:0] RS_NOT_FOUND = 3'd2;
  localparam logic [2:0] RS_IS_IDLE   = 3'd3;
  localparam logic [2:0] RS_IS_CUR    = 3'd4;
  localparam logic [2:0] RS_BAD_REQ   = 3'd5;
  localparam logic [2:0] RS_EMPTY     = 3'd6;

  // slot states
  localparam logic [1:0] SS_UNUSED  = 2'd0;
  localparam logic [1:0] SS_READY   = 2'd1;
  localparam logic [1:0] SS_RUNNING = 2'd2;
  localparam logic [1:0] SS_BLOCKED = 2'd3;

  typedef struct packed {
    logic [3:0]  operation;
    logic [3:0]  slot;
    logic [15:0] target_id;
    logic [31:0] sleep_ticks;
    logic [31:0] now_tick;
    logic        make_idle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  chosen_slot;
    logic [15:0] chosen_id;
    logic [4:0]  live_count;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_MOD,
    DP_SCAN,
    DP_APPLY,
    DP_CLEAR,
    DP_CSTART,
    DP_COUNT,
    DP_EMIT
  } dp_cmd_e;

  typedef struct packed {
    logic mod_done;
    logic scan_done;
    logic clear_done;
    logic count_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/round_robin_task_scheduler.sv =====
// Round-robin task table: one command beat in, one result beat out.
// Input channel: in_valid_i / in_stall_o carry an in_item_t (operation, slot,
// target_id, sleep_ticks, now_tick, make_idle). Output channel: out_valid_o /
// out_stall_i carry an out_item_t (status, chosen_slot, chosen_id, live_count).
// A beat moves on a rising edge where valid is high and stall is low.
// One command is worked at a time; in_stall_o stays high from acceptance
// until its result beat is taken. Each command runs a wrap step (schedule
// only, bringing its start position below the count of slots in use), a
// search of the slots in use, a clearing sweep up to TASK_SLOTS (compact
// only) and a live count over the slots in use. The slot scan visits one
// entry per cycle. Reset clears the whole table at once; the first command
// is taken in the cycle after reset is released. While the receiver stalls,
// the result beat holds and no new command is taken.
`default_nettype none

`include "round_robin_task_scheduler_assert.svh"

module round_robin_task_scheduler #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rrts_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rrts_pkg::out_item_t out_data_o
);
  import rrts_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t stat;

  // sequencer: walks the command through its scan phases
  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // task table, scan registers and result register
  rrts_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  // a pending result keeps the input side closed
  `RRTS_ASSERT_IMP(a_busy_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  // an accepted command closes the input side next cycle
  `RRTS_ASSERT_NEXT(a_stall_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // a refused command never reports a slot
  `RRTS_ASSERT_IMP(a_no_pick_on_error, clk_i, rst_ni, out_valid_o && out_data_o.status != RS_OK, out_data_o.chosen_slot == 4'd0 && out_data_o.chosen_id == 16'd0)
  // live count never exceeds the table size
  `RRTS_ASSERT_IMP(a_live_bound, clk_i, rst_ni, out_valid_o, 32'(out_data_o.live_count) <= 32'(TASK_SLOTS))

endmodule

`default_nettype wire

// ===== design/rrts_datapath.sv =====
`default_nettype none

module rrts_datapath #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrts_pkg::dp_cmd_e   cmd_i,
  input  rrts_pkg::in_item_t  in_data_i,
  output rrts_pkg::dp_status_t stat_o,
  output rrts_pkg::out_item_t out_data_o
);
  import rrts_pkg::*;

  localparam int unsigned SW = $clog2(TASK_SLOTS);
  localparam int unsigned KW = $clog2(TASK_SLOTS + 1);
  localparam logic [KW-1:0] SLOTS_K = KW'(TASK_SLOTS);

  logic [1:0]    st_q  [TASK_SLOTS];
  logic          idl_q [TASK_SLOTS];
  logic [15:0]   id_q  [TASK_SLOTS];
  logic [31:0]   wk_q  [TASK_SLOTS];

  logic [KW-1:0] cnt_q, k_q, p_q, wr_q, live_q;
  logic [SW-1:0] cur_q, idle_q, fidx_q, pick_q;
  logic          cur_v_q, idle_v_q, found_q, has_pick_q;
  logic [15:0]   idc_q;
  logic [2:0]    res_q;
  in_item_t      cmd_q;
  out_item_t     out_q;

  logic [SW-1:0] kx, px, wx, sidx, cr_at;
  logic          slot_ok, sched_act, create_act, scans;

  assign kx    = k_q[SW-1:0];
  assign px    = p_q[SW-1:0];
  assign wx    = wr_q[SW-1:0];
  assign sidx  = SW'(cmd_q.slot);
  assign cr_at = found_q ? fidx_q : cnt_q[SW-1:0];
  assign slot_ok = 32'(cmd_q.slot) < 32'(TASK_SLOTS);

  assign sched_act  = (cmd_q.operation == OP_SCHEDULE) && (cnt_q != '0) && cur_v_q;
  assign create_act = (cmd_q.operation == OP_CREATE) && (cnt_q < SLOTS_K) &&
                      !(cmd_q.make_idle && idle_v_q);
  assign scans = sched_act || create_act || (cmd_q.operation == OP_DELETE) ||
                 (cmd_q.operation == OP_TICK) || (cmd_q.operation == OP_COMPACT);

  assign stat_o.mod_done   = !sched_act || (p_q < cnt_q);
  assign stat_o.scan_done  = !scans || found_q || (k_q == cnt_q);
  assign stat_o.clear_done = (cmd_q.operation != OP_COMPACT) || (k_q == SLOTS_K);
  assign stat_o.count_done = (k_q == cnt_q);
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        st_q[i]  <= SS_UNUSED;
        idl_q[i] <= 1'b0;
        id_q[i]  <= '0;
        wk_q[i]  <= '0;
      end
      cnt_q <= '0; k_q <= '0; p_q <= '0; wr_q <= '0; live_q <= '0;
      cur_q <= '0; idle_q <= '0; fidx_q <= '0; pick_q <= '0;
      cur_v_q <= 1'b0; idle_v_q <= 1'b0; found_q <= 1'b0; has_pick_q <= 1'b0;
      idc_q <= '0; res_q <= RS_OK; cmd_q <= '0; out_q <= '0;
    end else begin
      unique case (cmd_i)
        DP_LOAD: begin
          cmd_q   <= in_data_i;
          k_q     <= '0;
          wr_q    <= '0;
          found_q <= 1'b0;
          p_q     <= KW'(cur_q) + KW'(1);
          // demote the running task before the search
          if (in_data_i.operation == OP_SCHEDULE && cnt_q != '0 && cur_v_q &&
              st_q[cur_q] == SS_RUNNING) begin
            st_q[cur_q] <= SS_READY;
          end
        end
        DP_MOD: p_q <= p_q - cnt_q;
        DP_SCAN: begin
          k_q <= k_q + KW'(1);
          unique case (cmd_q.operation)
            OP_SCHEDULE: begin
              if (st_q[px] == SS_READY && !idl_q[px] && wk_q[px] == '0) begin
                found_q <= 1'b1;
                fidx_q  <= px;
              end
              p_q <= (p_q + KW'(1) == cnt_q) ? '0 : p_q + KW'(1);
            end
            OP_CREATE: begin
              if (st_q[kx] == SS_UNUSED) begin
                found_q <= 1'b1;
                fidx_q  <= kx;
              end
            end
            OP_DELETE: begin
              if (id_q[kx] == cmd_q.target_id) begin
                found_q <= 1'b1;
                fidx_q  <= kx;
              end
            end
            OP_TICK: begin
              if (st_q[kx] == SS_BLOCKED && wk_q[kx] != '0 &&
                  cmd_q.now_tick >= wk_q[kx]) begin
                st_q[kx] <= SS_READY;
                wk_q[kx] <= '0;
              end
            end
            OP_COMPACT: begin
              if (st_q[kx] != SS_UNUSED) begin
                if (k_q != wr_q) begin
                  st_q[wx]  <= st_q[kx];
                  idl_q[wx] <= idl_q[kx];
                  id_q[wx]  <= id_q[kx];
                  wk_q[wx]  <= wk_q[kx];
                  if (cur_v_q && cur_q == kx) cur_q <= wx;
                  if (idle_v_q && idle_q == kx) idle_q <= wx;
                end
                wr_q <= wr_q + KW'(1);
              end
            end
            default: ;
          endcase
        end
        DP_APPLY: begin
          unique case (cmd_q.operation)
            OP_SCHEDULE: begin
              if (cnt_q == '0) begin
                res_q      <= RS_EMPTY;
                has_pick_q <= 1'b0;
              end else begin
                res_q      <= RS_OK;
                has_pick_q <= 1'b1;
                if (!cur_v_q) begin
                  cur_q   <= '0;
                  cur_v_q <= 1'b1;
                  st_q[0] <= SS_RUNNING;
                  pick_q  <= '0;
                end else if (found_q) begin
                  cur_q        <= fidx_q;
                  st_q[fidx_q] <= SS_RUNNING;
                  pick_q       <= fidx_q;
                end else if (idle_v_q && st_q[idle_q] == SS_READY) begin
                  cur_q        <= idle_q;
                  st_q[idle_q] <= SS_RUNNING;
                  pick_q       <= idle_q;
                end else begin
                  st_q[cur_q] <= SS_RUNNING;
                  pick_q      <= cur_q;
                end
              end
            end
            OP_CREATE: begin
              if (cnt_q >= SLOTS_K) begin
                res_q      <= RS_FULL;
                has_pick_q <= 1'b0;
              end else if (cmd_q.make_idle && idle_v_q) begin
                res_q      <= RS_BAD_REQ;
                has_pick_q <= 1'b0;
              end else begin
                res_q        <= RS_OK;
                idc_q        <= idc_q + 16'd1;
                st_q[cr_at]  <= SS_READY;
                idl_q[cr_at] <= cmd_q.make_idle;
                id_q[cr_at]  <= idc_q + 16'd1;
                wk_q[cr_at]  <= '0;
                if (!found_q) cnt_q <= cnt_q + KW'(1);
                if (cmd_q.make_idle) begin
                  idle_q   <= cr_at;
                  idle_v_q <= 1'b1;
                end
                pick_q     <= cr_at;
                has_pick_q <= 1'b1;
              end
            end
            OP_DELETE: begin
              has_pick_q <= 1'b0;
              if (!found_q) begin
                res_q <= RS_NOT_FOUND;
              end else if (idl_q[fidx_q]) begin
                res_q <= RS_IS_IDLE;
              end else if (cur_v_q && cur_q == fidx_q) begin
                res_q <= RS_IS_CUR;
              end else begin
                res_q        <= RS_OK;
                st_q[fidx_q] <= SS_UNUSED;
                id_q[fidx_q] <= '0;
              end
            end
            OP_BLOCK: begin
              has_pick_q <= 1'b0;
              if (!slot_ok) begin
                res_q <= RS_BAD_REQ;
              end else begin
                res_q <= RS_OK;
                if (st_q[sidx] != SS_UNUSED && !idl_q[sidx]) st_q[sidx] <= SS_BLOCKED;
              end
            end
            OP_UNBLOCK: begin
              has_pick_q <= 1'b0;
              if (!slot_ok) begin
                res_q <= RS_BAD_REQ;
              end else begin
                res_q <= RS_OK;
                if (st_q[sidx] == SS_BLOCKED) st_q[sidx] <= SS_READY;
              end
            end
            OP_SLEEP: begin
              has_pick_q <= 1'b0;
              if (cmd_q.sleep_ticks == '0 || !cur_v_q) begin
                res_q <= RS_BAD_REQ;
              end else begin
                res_q       <= RS_OK;
                wk_q[cur_q] <= cmd_q.now_tick + cmd_q.sleep_ticks;
                if (st_q[cur_q] != SS_UNUSED && !idl_q[cur_q]) st_q[cur_q] <= SS_BLOCKED;
              end
            end
            OP_TICK: begin
              res_q      <= RS_OK;
              has_pick_q <= 1'b0;
            end
            OP_EXIT: begin
              has_pick_q <= 1'b0;
              if (!cur_v_q) begin
                res_q <= RS_BAD_REQ;
              end else begin
                res_q       <= RS_OK;
                st_q[cur_q] <= SS_UNUSED;
                id_q[cur_q] <= '0;
              end
            end
            OP_COMPACT: begin
              res_q      <= RS_OK;
              has_pick_q <= 1'b0;
              cnt_q      <= wr_q;
              k_q        <= wr_q;
            end
            default: begin
              res_q      <= RS_BAD_REQ;
              has_pick_q <= 1'b0;
            end
          endcase
        end
        DP_CLEAR: begin
          st_q[kx]  <= SS_UNUSED;
          idl_q[kx] <= 1'b0;
          id_q[kx]  <= '0;
          wk_q[kx]  <= '0;
          k_q       <= k_q + KW'(1);
        end
        DP_CSTART: begin
          k_q    <= '0;
          live_q <= '0;
        end
        DP_COUNT: begin
          if (st_q[kx] != SS_UNUSED) live_q <= live_q + KW'(1);
          k_q <= k_q + KW'(1);
        end
        DP_EMIT: begin
          out_q.status      <= res_q;
          out_q.chosen_slot <= has_pick_q ? 4'(pick_q) : 4'd0;
          out_q.chosen_id   <= has_pick_q ? id_q[pick_q] : 16'd0;
          out_q.live_count  <= 5'(live_q);
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rrts_ctrl.sv =====
`default_nettype none

module rrts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  rrts_pkg::dp_status_t stat_i,
  output rrts_pkg::dp_cmd_e    cmd_o
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_SCAN, S_APPLY, S_CLEAR, S_COUNT, S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = DP_NONE;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o   = DP_LOAD;
        state_d = S_MOD;
      end
      S_MOD: if (stat_i.mod_done) state_d = S_SCAN; else cmd_o = DP_MOD;
      S_SCAN: if (stat_i.scan_done) state_d = S_APPLY; else cmd_o = DP_SCAN;
      S_APPLY: begin
        cmd_o   = DP_APPLY;
        state_d = S_CLEAR;
      end
      S_CLEAR: if (stat_i.clear_done) begin
        cmd_o   = DP_CSTART;
        state_d = S_COUNT;
      end else begin
        cmd_o = DP_CLEAR;
      end
      S_COUNT: if (stat_i.count_done) begin
        cmd_o   = DP_EMIT;
        state_d = S_OUT;
      end else begin
        cmd_o = DP_COUNT;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;

  // Software copy of the task table; predicts one result per command beat.
  class task_table_sb;
    logic [1:0]  st [SLOTS];
    bit          idle_mark [SLOTS];
    logic [15:0] ident [SLOTS];
    logic [31:0] wake [SLOTS];
    int unsigned count;
    int unsigned cur;
    bit          cur_ok;
    int unsigned idl;
    bit          idl_ok;
    logic [15:0] last_id;
    out_item_t   pending [$];
    int          mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        st[i] = SS_UNUSED; idle_mark[i] = 0; ident[i] = '0; wake[i] = '0;
      end
      count = 0; cur = 0; cur_ok = 0; idl = 0; idl_ok = 0; last_id = '0;
      mismatches = 0;
    endfunction

    function void wipe(int unsigned i);
      st[i] = SS_UNUSED; idle_mark[i] = 0; ident[i] = '0; wake[i] = '0;
    endfunction

    function logic [2:0] pick_next(output int unsigned pick);
      int unsigned nxt;
      if (count == 0) return RS_EMPTY;
      if (!cur_ok) begin
        cur = 0; cur_ok = 1; st[0] = SS_RUNNING; pick = 0;
        return RS_OK;
      end
      nxt = (cur + 1) % count;
      if (st[cur] == SS_RUNNING) st[cur] = SS_READY;
      for (int i = 0; i < count; i++) begin
        if (st[nxt] == SS_READY && !idle_mark[nxt] && wake[nxt] == 0) begin
          cur = nxt; st[nxt] = SS_RUNNING; pick = nxt;
          return RS_OK;
        end
        nxt = (nxt + 1) % count;
      end
      if (idl_ok && st[idl] == SS_READY) begin
        st[idl] = SS_RUNNING; cur = idl; pick = idl;
        return RS_OK;
      end
      st[cur] = SS_RUNNING; pick = cur;
      return RS_OK;
    endfunction

    function logic [2:0] add_task(bit as_idle, output int unsigned pick);
      int unsigned at;
      if (count >= SLOTS) return RS_FULL;
      if (as_idle && idl_ok) return RS_BAD_REQ;
      at = count;
      for (int i = 0; i < count; i++)
        if (st[i] == SS_UNUSED) begin at = i; break; end
      last_id = last_id + 16'd1;
      st[at] = SS_READY; idle_mark[at] = as_idle; ident[at] = last_id; wake[at] = '0;
      if (at == count) count++;
      if (as_idle) begin idl = at; idl_ok = 1; end
      pick = at;
      return RS_OK;
    endfunction

    function logic [2:0] remove_task(logic [15:0] id);
      for (int i = 0; i < count; i++)
        if (ident[i] == id) begin
          if (idle_mark[i]) return RS_IS_IDLE;
          if (cur_ok && cur == i) return RS_IS_CUR;
          st[i] = SS_UNUSED; ident[i] = '0;
          return RS_OK;
        end
      return RS_NOT_FOUND;
    endfunction

    function void squeeze();
      int unsigned wr;
      wr = 0;
      for (int rd = 0; rd < count; rd++) begin
        if (st[rd] == SS_UNUSED) continue;
        if (rd != wr) begin
          st[wr] = st[rd]; idle_mark[wr] = idle_mark[rd];
          ident[wr] = ident[rd]; wake[wr] = wake[rd];
          if (cur_ok && cur == rd) cur = wr;
          if (idl_ok && idl == rd) idl = wr;
        end
        wr++;
      end
      count = wr;
      for (int i = wr; i < SLOTS; i++) wipe(i);
    endfunction

    function void note_command(in_item_t c);
      out_item_t r;
      int unsigned pick;
      bit has_pick;
      int unsigned live;
      r = '0; pick = 0; has_pick = 0;
      case (c.operation)
        OP_SCHEDULE: begin r.status = pick_next(pick); has_pick = (r.status == RS_OK); end
        OP_CREATE: begin r.status = add_task(c.make_idle, pick); has_pick = (r.status == RS_OK); end
        OP_DELETE: r.status = remove_task(c.target_id);
        OP_BLOCK: if (st[c.slot] != SS_UNUSED && !idle_mark[c.slot]) st[c.slot] = SS_BLOCKED;
        OP_UNBLOCK: if (st[c.slot] == SS_BLOCKED) st[c.slot] = SS_READY;
        OP_SLEEP: begin
          if (c.sleep_ticks == 0 || !cur_ok) r.status = RS_BAD_REQ;
          else begin
            wake[cur] = c.now_tick + c.sleep_ticks;
            if (st[cur] != SS_UNUSED && !idle_mark[cur]) st[cur] = SS_BLOCKED;
          end
        end
        OP_TICK:
          for (int i = 0; i < count; i++)
            if (st[i] == SS_BLOCKED && wake[i] != 0 && c.now_tick >= wake[i]) begin
              st[i] = SS_READY; wake[i] = '0;
            end
        OP_EXIT: begin
          if (!cur_ok) r.status = RS_BAD_REQ;
          else begin st[cur] = SS_UNUSED; ident[cur] = '0; end
        end
        OP_COMPACT: squeeze();
        default: r.status = RS_BAD_REQ;
      endcase
      if (has_pick) begin
        r.chosen_slot = pick[3:0];
        r.chosen_id = ident[pick];
      end
      live = 0;
      for (int i = 0; i < count; i++) if (st[i] != SS_UNUSED) live++;
      r.live_count = live[4:0];
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      bad = (got.status !== want.status) || (got.chosen_slot !== want.chosen_slot) ||
            (got.chosen_id !== want.chosen_id) || (got.live_count !== want.live_count);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  task_table_sb sb;
  int unsigned cycles;
  int unsigned stall_mode;

  round_robin_task_scheduler #(.TASK_SLOTS(SLOTS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Drive one command beat and hold it until the block takes it.
  task send_command(in_item_t c);
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(c);
  endtask

  // Drop valid for a random gap; a zero gap keeps the burst going.
  task idle_gap(int unsigned n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic in_item_t make_cmd(logic [3:0] op);
    in_item_t c;
    c.operation   = op;
    c.slot        = 4'($urandom_range(0, 15));
    c.target_id   = 16'($urandom);
    c.sleep_ticks = 32'($urandom);
    c.now_tick    = 32'($urandom);
    c.make_idle   = 1'($urandom);
    return c;
  endfunction

  // Bias the command mix towards well-formed traffic; ids near the live range.
  function automatic in_item_t random_cmd();
    in_item_t c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25)      c = make_cmd(OP_SCHEDULE);
    else if (r < 42) c = make_cmd(OP_CREATE);
    else if (r < 50) c = make_cmd(OP_DELETE);
    else if (r < 58) c = make_cmd(OP_BLOCK);
    else if (r < 66) c = make_cmd(OP_UNBLOCK);
    else if (r < 74) c = make_cmd(OP_SLEEP);
    else if (r < 84) c = make_cmd(OP_TICK);
    else if (r < 90) c = make_cmd(OP_EXIT);
    else if (r < 96) c = make_cmd(OP_COMPACT);
    else             c = make_cmd(4'($urandom_range(9, 15)));
    if (c.operation == OP_CREATE) c.make_idle = ($urandom_range(0, 9) == 0);
    if (c.operation == OP_DELETE && $urandom_range(0, 3) != 0)
      c.target_id = sb.last_id - 16'($urandom_range(0, 20));
    if (c.operation == OP_SLEEP && $urandom_range(0, 3) != 0)
      c.sleep_ticks = $urandom_range(1, 50);
    if (c.operation == OP_SLEEP && $urandom_range(0, 9) == 0) c.sleep_ticks = '0;
    if (c.operation == OP_SLEEP || c.operation == OP_TICK)
      if ($urandom_range(0, 3) != 0) c.now_tick = $urandom_range(0, 200);
    return c;
  endfunction

  // Receiver stall pattern: several modes, including no stalling at all.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= (cycles % 7) < 3;
      endcase
    end
  end

  // Check every result beat as it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_item_t c;
    sb = new();
    cycles = 0;
    stall_mode = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, no-current cases, fill, extremes, idle rules.
    send_command(make_cmd(OP_SCHEDULE));
    c = make_cmd(OP_SLEEP); c.sleep_ticks = 32'd5; send_command(c);
    send_command(make_cmd(OP_EXIT));
    c = make_cmd(OP_CREATE); c.make_idle = 1; send_command(c);
    c = make_cmd(OP_CREATE); c.make_idle = 1; send_command(c);
    c = make_cmd(OP_DELETE); c.target_id = 16'd1; send_command(c);
    for (int i = 0; i < 16; i++) begin
      c = make_cmd(OP_CREATE); c.make_idle = 0; send_command(c);
    end
    send_command(make_cmd(OP_SCHEDULE));
    c = make_cmd(OP_SLEEP); c.sleep_ticks = 32'hFFFF_FFFF; c.now_tick = 32'd1; send_command(c);
    c = make_cmd(OP_SLEEP); c.sleep_ticks = '0; send_command(c);
    c = make_cmd(OP_TICK); c.now_tick = 32'hFFFF_FFFF; send_command(c);
    c = make_cmd(OP_BLOCK); c.slot = 4'd15; send_command(c);
    c = make_cmd(OP_UNBLOCK); c.slot = 4'd0; send_command(c);
    c = make_cmd(OP_DELETE); c.target_id = 16'hFFFF; send_command(c);
    send_command(make_cmd(OP_EXIT));
    send_command(make_cmd(OP_COMPACT));
    send_command(make_cmd(4'hF));

    // Random bursts with occasional idle gaps; exits and compacts free and squeeze the table.
    for (int n = 0; n < 1600; n++) begin
      send_command(random_cmd());
      if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(0, 12));
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/rrts_pkg.sv
design/rrts_datapath.sv
design/rrts_ctrl.sv
design/round_robin_task_scheduler.sv
tb/tb_top.sv
